/* sv/asld_pkg.sv */
// ----------------------------------------------------------------------------
// asld_pkg
// shared types and constants for the adaptive sound level detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asld_pkg;

	// fixed field widths
	localparam int SAMPLE_W  = 16;
	localparam int MAG4_W    = 18;   // |sample| << 2 fits in 18 bits
	localparam int LEVEL_W   = 18;
	localparam int FLOOR_W   = 18;
	localparam int THR_W     = 20;
	localparam int TICK_W    = 16;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// register select (paddr bit 2)
	localparam logic REG_MIN_TRIG = 1'b0;
	localparam logic REG_COOLDOWN = 1'b1;

	localparam logic [THR_W-1:0]  MIN_TRIG_RST = 20'd800;
	localparam logic [TICK_W-1:0] COOLDOWN_RST = 16'd400;

	// command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic                       command;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_last;
	} item_t;

	typedef struct packed {
		logic               detected;
		logic [LEVEL_W-1:0] level;
		logic [THR_W-1:0]   threshold;
		logic               seeding;
	} result_t;

	// control from the sequencer to a serial unit
	typedef struct packed {
		logic start;
		logic clear;
	} ser_ctl_t;

endpackage

/* sv/asld_ser_acc.sv */
// ----------------------------------------------------------------------------
// asld_ser_acc
// bit-serial accumulator: adds one operand to the running sum, lsb first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asld_ser_acc #(
	parameter int SUM_W = 28
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  asld_pkg::ser_ctl_t   ctl,
	input  logic [SUM_W-1:0]     addend,
	output logic                 busy,
	output logic [SUM_W-1:0]     sum
);
	import asld_pkg::*;

	localparam int CW = (SUM_W > 1) ? $clog2(SUM_W) : 1;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] add_q;
	logic             carry_q;
	logic             busy_q;
	logic [CW-1:0]    bit_q;
	logic             s_bit;
	logic             c_next;

	// full adder on the low bits
	assign s_bit  = sum_q[0] ^ add_q[0] ^ carry_q;
	assign c_next = (sum_q[0] & add_q[0]) | (carry_q & (sum_q[0] ^ add_q[0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			busy_q  <= 1'b0;
			carry_q <= 1'b0;
			bit_q   <= '0;
		end else if (ctl.clear) begin
			sum_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q  <= 1'b1;
			carry_q <= 1'b0;
			bit_q   <= '0;
		end else if (busy_q) begin
			sum_q   <= {s_bit, sum_q[SUM_W-1:1]};
			carry_q <= c_next;
			bit_q   <= bit_q + 1'b1;
			if (bit_q == CW'(SUM_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start)
			add_q <= addend;
		else if (busy_q)
			add_q <= {1'b0, add_q[SUM_W-1:1]};
	end

	assign busy = busy_q;
	assign sum  = sum_q;

endmodule

/* sv/asld_ser_div.sv */
// ----------------------------------------------------------------------------
// asld_ser_div
// restoring divider, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asld_ser_div #(
	parameter int SUM_W = 28,
	parameter int CNT_W = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  asld_pkg::ser_ctl_t            ctl,
	input  logic [SUM_W-1:0]              dividend,
	input  logic [CNT_W-1:0]              divisor,
	output logic                          busy,
	output logic [asld_pkg::LEVEL_W-1:0]  quotient
);
	import asld_pkg::*;

	localparam int CW = (SUM_W > 1) ? $clog2(SUM_W) : 1;

	logic [SUM_W-1:0] num_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dsr_q;
	logic             busy_q;
	logic [CW-1:0]    step_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, num_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.clear) begin
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == CW'(SUM_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SUM_W-2:0], 1'b0};
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q[LEVEL_W-1:0];

endmodule

/* sv/adaptive_sound_level_detector.sv */
// ----------------------------------------------------------------------------
// adaptive_sound_level_detector
// mean absolute level per block against an adaptive noise floor
// a counted sample word stalls the input while it is added serially, until
// the sequencer sees the adder finish; a block-closing word keeps it stalled
// through the serial divide and a decision step, which registers the result
// and waits while the result register is stalled; tick words do not leave
// idle; reset clears sums, counts, floor, tick count and loads register
// defaults (SUM_W = 18 + clog2(BLOCK_MAX), 28 by default)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_sound_level_detector #(
	parameter int BLOCK_MAX = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  asld_pkg::item_t               item,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output asld_pkg::result_t             result,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [asld_pkg::APB_AW-1:0]   paddr,
	input  logic [asld_pkg::APB_DW-1:0]   pwdata,
	output logic [asld_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import asld_pkg::*;

	// sum must hold BLOCK_MAX magnitudes of up to 2^17
	localparam int LOG_BM = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 0;
	localparam int SUM_W  = MAG4_W + LOG_BM;
	localparam int CNT_W  = $clog2(BLOCK_MAX + 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ACC  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DEC  = 2'd3;

	logic [1:0]          state_q;
	logic                last_q;      // current sample closes the block
	logic                div_go_q;    // one-cycle start towards the divider
	logic [CNT_W-1:0]    count_q;
	logic [FLOOR_W-1:0]  floor_q;
	logic                floor_ready_q;
	logic [TICK_W-1:0]   ticks_q;
	logic [THR_W-1:0]    min_trig_q;
	logic [TICK_W-1:0]   cooldown_q;
	logic                res_valid_q;
	result_t             res_q;

	// ---------------------------------------------------------------- registers
	logic cfg_wr;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_trig_q <= MIN_TRIG_RST;
			cooldown_q <= COOLDOWN_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_MIN_TRIG: min_trig_q <= pwdata[THR_W-1:0];
				REG_COOLDOWN: cooldown_q <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_MIN_TRIG: prdata = {{(APB_DW-THR_W){1'b0}}, min_trig_q};
			REG_COOLDOWN: prdata = {{(APB_DW-TICK_W){1'b0}}, cooldown_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- input side
	logic                take;
	logic                is_tick;
	logic                counted;
	logic [SAMPLE_W:0]   sx;
	logic [SAMPLE_W-1:0] mag;
	logic [MAG4_W-1:0]   mag4;

	// only the idle sequencer takes a word; results wait in their own register
	assign item_stall = (state_q != ST_IDLE);
	assign take       = item_valid & ~item_stall;
	assign is_tick    = (item.command == CMD_TICK);
	assign counted    = (count_q < CNT_W'(BLOCK_MAX));

	// magnitude of the sign-extended sample; -32768 gives 32768, still 16 bits
	assign sx   = {item.sample[SAMPLE_W-1], item.sample};
	assign mag  = sx[SAMPLE_W] ? SAMPLE_W'(~sx + 1'b1) : sx[SAMPLE_W-1:0];
	assign mag4 = {mag, 2'b00};

	// ---------------------------------------------------------------- serial units
	ser_ctl_t         acc_ctl;
	ser_ctl_t         div_ctl;
	logic             acc_busy;
	logic             div_busy;
	logic [SUM_W-1:0] sum;
	logic [LEVEL_W-1:0] quotient;
	logic             dec_fire;   // decision step writes the result register
	logic             out_free;

	assign out_free = ~res_valid_q | ~result_stall;
	assign dec_fire = (state_q == ST_DEC) & out_free;

	assign acc_ctl.start = take & ~is_tick & counted;
	assign acc_ctl.clear = dec_fire;
	assign div_ctl.start = div_go_q;
	assign div_ctl.clear = 1'b0;

	asld_ser_acc #(
		.SUM_W (SUM_W)
	) u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.addend (SUM_W'(mag4)),
		.busy   (acc_busy),
		.sum    (sum)
	);

	asld_ser_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (sum),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// ---------------------------------------------------------------- decision
	logic [LEVEL_W-1:0] level;
	logic [THR_W-1:0]   thr5;
	logic [THR_W-1:0]   thr;
	logic               above;
	logic               cool_ok;
	logic [23:0]        floor_mix;
	logic [FLOOR_W-1:0] floor_new;

	// an empty block reads as level zero
	assign level   = (count_q == '0) ? '0 : quotient;
	assign thr5    = {floor_q, 2'b00} + THR_W'(floor_q);
	assign thr     = (thr5 < min_trig_q) ? min_trig_q : thr5;
	assign above   = (THR_W'(level) > thr);
	assign cool_ok = (ticks_q >= cooldown_q);

	// (31 * floor + level) / 32 as (32 * floor - floor + level) >> 5
	assign floor_mix = {1'b0, floor_q, 5'b00000} - 24'(floor_q) + 24'(level);
	assign floor_new = floor_mix[FLOOR_W+4:5];

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_q        <= 1'b0;
			div_go_q      <= 1'b0;
			count_q       <= '0;
			floor_q       <= '0;
			floor_ready_q <= 1'b0;
			ticks_q       <= '0;
		end else begin
			div_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (is_tick) begin
							// saturating tick count
							if (ticks_q != '1)
								ticks_q <= ticks_q + 1'b1;
						end else begin
							last_q <= item.block_last;
							if (counted) begin
								count_q <= count_q + 1'b1;
								state_q <= ST_ACC;
							end else if (item.block_last) begin
								// overfull block: the word still closes it
								div_go_q <= 1'b1;
								state_q  <= ST_DIV;
							end
						end
					end
				end
				ST_ACC: begin
					if (!acc_busy) begin
						if (last_q) begin
							div_go_q <= 1'b1;
							state_q  <= ST_DIV;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIV: begin
					if (!div_go_q && !div_busy)
						state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (out_free) begin
						count_q <= '0;
						state_q <= ST_IDLE;
						if (!floor_ready_q) begin
							// first block only seeds the floor
							floor_q       <= level;
							floor_ready_q <= 1'b1;
						end else begin
							if (above && cool_ok)
								ticks_q <= '0;
							if (!above)
								floor_q <= floor_new;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (dec_fire)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (dec_fire) begin
			res_q.level <= level;
			if (!floor_ready_q) begin
				res_q.detected  <= 1'b0;
				res_q.threshold <= '0;
				res_q.seeding   <= 1'b1;
			end else begin
				res_q.detected  <= above & cool_ok;
				res_q.threshold <= thr;
				res_q.seeding   <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// ---------------------------------------------------------------- checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BLOCK_MAX))
		else $error("block count beyond its limit");

	a_units_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc_busy && div_busy))
		else $error("accumulator and divider busy together");

	a_seed_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.seeding) |-> (!result.detected && result.threshold == '0))
		else $error("seeding word carries a detection or threshold");

	a_dec_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dec_fire |=> (state_q == ST_IDLE && result_valid))
		else $error("decision step did not deliver a word");

endmodule

/* tb/asld_level_check.sv */
// ----------------------------------------------------------------------------
// asld_level_check
// watches the word, result and register channels of the sound level detector,
// keeps its own copy of the detector state and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asld_level_check #(
	parameter int BLOCK_MAX = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic                        item_stall,
	input  asld_pkg::item_t             item,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  asld_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [asld_pkg::APB_AW-1:0] paddr,
	input  logic [asld_pkg::APB_DW-1:0] pwdata,
	input  logic [asld_pkg::APB_DW-1:0] prdata,
	input  logic                        end_check,
	output int                          fail_count,
	output int                          results_owed
);

	import asld_pkg::*;

	localparam int CNT_W = $clog2(BLOCK_MAX + 1);
	localparam int SUM_W = MAG4_W + $clog2(BLOCK_MAX);

	// register copies
	logic [THR_W-1:0]   min_trig;
	logic [TICK_W-1:0]  cooldown;

	// detector state copy
	logic [SUM_W-1:0]   level_sum;
	logic [CNT_W-1:0]   n_taken;
	logic [FLOOR_W-1:0] floor_lvl;
	logic               floor_set;
	logic [TICK_W-1:0]  ticks;

	result_t owed_results[$];
	int      fails;
	bit      ended;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
		fails++;
	endtask

	// fold one accepted word into the state, queue a result on block end
	task automatic absorb_word(input item_t w);
		logic [16:0] mag;
		logic [31:0] lvl;
		logic [31:0] thr;
		result_t     r;
		if (w.command == CMD_TICK) begin
			if (ticks != 16'hFFFF)
				ticks = ticks + 16'd1;
		end else begin
			if (n_taken < BLOCK_MAX) begin
				mag = w.sample[15] ? (17'h10000 - {1'b0, w.sample}) : {1'b0, w.sample};
				level_sum = level_sum + {mag, 2'b00};
				n_taken = n_taken + 1'b1;
			end
			if (w.block_last) begin
				lvl = (n_taken != 0) ? level_sum / n_taken : 32'd0;
				level_sum = '0;
				n_taken = '0;
				r = '0;
				r.level = lvl[LEVEL_W-1:0];
				if (!floor_set) begin
					floor_lvl = lvl[FLOOR_W-1:0];
					floor_set = 1'b1;
					r.seeding = 1'b1;
				end else begin
					thr = floor_lvl * 5;
					if (thr < min_trig)
						thr = min_trig;
					if (lvl > thr && ticks >= cooldown) begin
						r.detected = 1'b1;
						ticks = '0;
					end
					if (lvl <= thr)
						floor_lvl = (floor_lvl * 31 + lvl) / 32;
					r.threshold = thr[THR_W-1:0];
				end
				owed_results.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		logic [31:0] reg_want;
		if (!arst_n) begin
			min_trig = MIN_TRIG_RST;
			cooldown = COOLDOWN_RST;
			level_sum = '0;
			n_taken = '0;
			floor_lvl = '0;
			floor_set = 1'b0;
			ticks = '0;
			owed_results.delete();
			fails = 0;
			ended = 1'b0;
		end else begin
			// register port
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[2])
						REG_MIN_TRIG: min_trig = pwdata[THR_W-1:0];
						REG_COOLDOWN: cooldown = pwdata[TICK_W-1:0];
					endcase
				end else begin
					reg_want = (paddr[2] == REG_MIN_TRIG) ? {12'd0, min_trig} : {16'd0, cooldown};
					if (prdata !== reg_want)
						flag_mismatch("register read", prdata, reg_want);
				end
			end
			// results first: none can stem from a word taken at this same edge
			if (result_valid && !result_stall) begin
				if (owed_results.size() == 0) begin
					flag_mismatch("result with none owed, level", result.level, 0);
				end else begin
					want = owed_results.pop_front();
					if (result.detected !== want.detected)
						flag_mismatch("detected", result.detected, want.detected);
					if (result.level !== want.level)
						flag_mismatch("level", result.level, want.level);
					if (result.threshold !== want.threshold)
						flag_mismatch("threshold", result.threshold, want.threshold);
					if (result.seeding !== want.seeding)
						flag_mismatch("seeding", result.seeding, want.seeding);
				end
			end
			if (item_valid && !item_stall)
				absorb_word(item);
			if (end_check && !ended) begin
				ended = 1'b1;
				if (owed_results.size() != 0)
					flag_mismatch("results never delivered", owed_results.size(), 0);
			end
		end
		fail_count <= fails;
		results_owed <= owed_results.size();
	end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// drives sample and tick words, register writes and back-pressure into the
// sound level detector; a checker alongside predicts and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import asld_pkg::*;

	localparam int BLOCK_MAX      = 1024;
	localparam int HOLD_CYCLES    = 2000;   // long receiver hold-off
	localparam int SETTLE_CYCLES  = 80;     // one sample plus a block close, with margin
	localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake at all

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;
	logic                  end_check;
	int                    fail_count;
	int                    results_owed;

	// idle percentages for each side, and hold-off requests to the receiver
	int                    send_idle;
	int                    recv_idle;
	int                    hold_asks;

	adaptive_sound_level_detector #(
		.BLOCK_MAX(BLOCK_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	asld_level_check #(
		.BLOCK_MAX(BLOCK_MAX)
	) u_level_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.end_check(end_check),
		.fail_count(fail_count),
		.results_owed(results_owed)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stall, or a long hold-off when one is asked for
	initial begin
		int hold_seen;
		hold_seen = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// watchdog: ends the run after too long without any handshake
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [15:0] rnd16();
		logic [31:0] r;
		r = $urandom;
		return r[15:0];
	endfunction

	function automatic logic coin();
		return $urandom_range(1) != 0;
	endfunction

	function automatic item_t make_word(input logic cmd, input logic [15:0] s,
			input logic last);
		item_t w;
		w.command = cmd;
		w.sample = s;
		w.block_last = last;
		return w;
	endfunction

	// sample of a given loudness class: quiet, mid, loud or anything
	function automatic logic [15:0] pick_sample(input int cls);
		int          m;
		logic        neg;
		logic [31:0] v;
		neg = coin();
		case (cls)
			0: m = $urandom_range(40);
			1: m = $urandom_range(3000);
			2: m = neg ? $urandom_range(32768, 12000) : $urandom_range(32767, 12000);
			default: return rnd16();
		endcase
		v = neg ? -m : m;
		return v[15:0];
	endfunction

	// offer one word and hold it until the detector takes it
	task automatic send_word(input item_t w);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// apb write: setup then access, then psel and penable drop before the task returns
	task automatic reg_write(input logic reg_sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// apb read; the checker compares prdata on the access edge
	task automatic reg_read(input logic reg_sel);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering, wait for every owed result, then let the pipeline drain
	task automatic wait_idle();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(input logic [31:0] min_level, input logic [31:0] cool);
		wait_idle();
		reg_write(REG_MIN_TRIG, min_level);
		reg_write(REG_COOLDOWN, cool);
		reg_read(REG_MIN_TRIG);
		reg_read(REG_COOLDOWN);
	endtask

	// mostly whole blocks with a few ticks ahead of each, plus some noise words
	task automatic run_random(input int n_words, input int max_ticks, input int press_at);
		int sent;
		int len;
		int cls;
		int roll;
		int k;
		bit pressed;
		sent = 0;
		pressed = 1'b0;
		while (sent < n_words) begin
			if (press_at >= 0 && !pressed && sent >= press_at) begin
				hold_asks <= hold_asks + 1;
				pressed = 1'b1;
			end
			if ($urandom_range(99) < 10) begin
				// noise: any field may take any value
				send_word(make_word(coin(), rnd16(), coin()));
				sent++;
			end else begin
				k = $urandom_range(max_ticks);
				repeat (k) begin
					send_word(make_word(CMD_TICK, rnd16(), coin()));
					sent++;
				end
				roll = $urandom_range(99);
				if (roll < 50)
					cls = 0;
				else if (roll < 65)
					cls = 1;
				else if (roll < 85)
					cls = 2;
				else
					cls = 3;
				// short blocks mostly, now and then a longer one
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
				for (int i = 0; i < len; i++) begin
					send_word(make_word(CMD_SAMPLE, pick_sample(cls), i == len - 1));
					sent++;
				end
			end
		end
	endtask

	initial begin
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		end_check = 1'b0;
		hold_asks = 0;
		send_idle = 33;
		recv_idle = 78;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults after reset
		reg_read(REG_MIN_TRIG);
		reg_read(REG_COOLDOWN);

		// seeding block, quiet so that the floor starts low
		send_word(make_word(CMD_SAMPLE, 16'd3, 1'b0));
		send_word(make_word(CMD_SAMPLE, 16'hFFFE, 1'b0));      // -2
		send_word(make_word(CMD_SAMPLE, 16'd5, 1'b1));
		// ticks ignore sample and block_last
		send_word(make_word(CMD_TICK, 16'hA5C3, 1'b1));
		send_word(make_word(CMD_TICK, 16'h5A3C, 1'b0));
		// loud block blocked by the cooldown
		send_word(make_word(CMD_SAMPLE, 16'h8000, 1'b0));      // most negative
		send_word(make_word(CMD_SAMPLE, 16'h7FFF, 1'b1));      // most positive
		// silent and single-sample blocks
		send_word(make_word(CMD_SAMPLE, 16'h0000, 1'b1));
		send_word(make_word(CMD_SAMPLE, 16'hFFFF, 1'b1));      // -1
		send_word(make_word(CMD_SAMPLE, 16'h0001, 1'b1));
		// full-scale block
		send_word(make_word(CMD_SAMPLE, 16'h7FFF, 1'b0));
		send_word(make_word(CMD_SAMPLE, 16'h8000, 1'b0));
		send_word(make_word(CMD_SAMPLE, 16'h8001, 1'b0));      // -32767
		send_word(make_word(CMD_SAMPLE, 16'h8000, 1'b1));
		send_word(make_word(CMD_TICK, 16'h7FFF, 1'b1));
		send_word(make_word(CMD_TICK, 16'h8000, 1'b0));

		run_random(60, 3, -1);

		// lowest threshold and no cooldown: detections on loud blocks
		load_regs(32'd0, 32'd0);
		run_random(60, 2, -1);

		// swap the idling sides; threshold at its top end
		send_idle = 78;
		recv_idle = 33;
		load_regs(32'd655360, 32'd3);
		run_random(60, 5, -1);

		// overfull block: full-scale samples up to the limit, the rest dropped
		for (int i = 0; i < BLOCK_MAX + 2; i++)
			send_word(make_word(CMD_SAMPLE, (i < BLOCK_MAX) ? 16'h8000 : rnd16(),
				i == BLOCK_MAX + 1));

		load_regs($urandom_range(4000), $urandom_range(12));
		run_random(60, 15, -1);

		// no idling; receiver holds off partway through so the input backs up
		send_idle = 0;
		recv_idle = 0;
		load_regs($urandom_range(655360), $urandom_range(8));
		run_random(60, 10, 20);

		// longest cooldown: too few ticks pass for a detection
		load_regs($urandom_range(2000), 32'd65535);
		repeat (20)
			send_word(make_word(CMD_TICK, rnd16(), coin()));
		send_word(make_word(CMD_SAMPLE, 16'h8000, 1'b0));
		send_word(make_word(CMD_SAMPLE, 16'h8000, 1'b1));
		send_word(make_word(CMD_TICK, rnd16(), coin()));
		send_word(make_word(CMD_SAMPLE, 16'h7FFF, 1'b1));

		wait_idle();
		end_check <= 1'b1;
		repeat (3) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
sv/asld_pkg.sv
sv/asld_ser_acc.sv
sv/asld_ser_div.sv
sv/adaptive_sound_level_detector.sv
tb/asld_level_check.sv
tb/tb.sv
